// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion clocked on clk_i, disabled in reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// implication helper
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/ppcu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppcu_pkg
// types and codes of the predator-prey cell engine
// ----------------------------------------------------------------------------
`default_nettype none
package ppcu_pkg;
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_READ3  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OC_RW        = 3'd0,
    OC_FISH_MOVE = 3'd1,
    OC_FISH_STAY = 3'd2,
    OC_SHARK_ATE = 3'd3,
    OC_SHARK_MOV = 3'd4,
    OC_SHARK_STY = 3'd5,
    OC_STARVED   = 3'd6,
    OC_EMPTY     = 3'd7
  } outcome_e;

  localparam logic [1:0] REG_FISH_BREED  = 2'd0;
  localparam logic [1:0] REG_SHARK_BREED = 2'd1;
  localparam logic [1:0] REG_STARVE      = 2'd2;

  typedef struct packed {
    logic [3:0] fish;
    logic [4:0] shark;
    logic [4:0] hunger;
  } cell_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDHERE,
    ST_SCAN,
    ST_SCANLAST,
    ST_DIV,
    ST_RDDEST,
    ST_WRDEST,
    ST_WRHERE,
    ST_RDOUT,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/core/predator_prey_cell_update.sv =====
// ----------------------------------------------------------------------------
// predator_prey_cell_update
// toroidal predator-prey grid held in one synchronous ram, updated in place
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// request   in         req_valid/ready  command, cell_x/y, ages, random_pick
// result    out        res_valid/ready  fish/shark age, hunger, dest, outcome
// cfg       in         cfg_we_i         cfg_index_i, cfg_data_i
//
// an update reads the eight neighbors through the single ram port; when the
//   animal eats or moves, a restoring remainder unit reduces the pick modulo
//   the candidate count before the destination cell is read and written
// reset: a clearing pass writes every cell to empty, and no request is
//   taken during it
// stalls: the result register holds until taken; the next request is taken
//   no earlier than the edge after the result is, since every command touches
//   the same ram port
`default_nettype none
`include "assert_macros.svh"
module predator_prey_cell_update #(
  parameter int GRID_WIDTH  = 128,
  parameter int GRID_HEIGHT = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [4:0] cfg_data_i,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [6:0] cell_x_i,
  input  wire logic [6:0] cell_y_i,
  input  wire logic [3:0] fish_age_in_i,
  input  wire logic [4:0] shark_age_in_i,
  input  wire logic [4:0] hunger_in_i,
  input  wire logic [15:0] random_pick_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [3:0]      fish_age_o,
  output logic [4:0]      shark_age_o,
  output logic [4:0]      hunger_o,
  output logic [6:0]      dest_x_o,
  output logic [6:0]      dest_y_o,
  output logic [2:0]      outcome_o
);
  import ppcu_pkg::*;

  localparam int Cells = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW = $clog2(Cells);
  localparam int CW = $clog2(Cells + 1);

  // config registers
  logic [3:0] fbreed_q;
  logic [4:0] sbreed_q, starve_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbreed_q <= 4'd4;
      sbreed_q <= 5'd10;
      starve_q <= 5'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FISH_BREED:  fbreed_q <= cfg_data_i[3:0];
        REG_SHARK_BREED: sbreed_q <= cfg_data_i;
        REG_STARVE:      starve_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // cell ram, one port
  cell_t mem [Cells];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  cell_t         mem_wd, mem_rd_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd_q <= mem[mem_addr];
  end

  state_e state_q, state_d;

  // request registers
  logic [1:0]  cmd_q;
  logic [6:0]  x_q, y_q;
  cell_t       win_q;
  logic [15:0] pick_q;
  cell_t       here_q;
  // scan
  logic [3:0]  scan_q;   // neighbor slot 0..8, slot 4 is the cell itself
  logic [3:0]  nfish_q, nfree_q;
  logic [7:0]  fmask_q, emask_q;
  // remainder unit
  logic [15:0] rem_q;
  logic [4:0]  dstep_q;
  // destination
  logic [6:0]  dx_q, dy_q;
  cell_t       dcell_q;
  logic [2:0]  oc_q;
  logic [CW-1:0] clr_q;
  logic        res_valid_q;

  function automatic logic [6:0] wrap_add(input logic [6:0] v, input logic [1:0] o,
                                          input int n);
    logic [7:0] s;
    s = {1'b0, v} + {6'd0, o};
    if (s == 8'd0) s = 8'(n);
    s = s - 8'd1;
    if (s >= 8'(n)) s = s - 8'(n);
    return s[6:0];
  endfunction

  function automatic logic [AW-1:0] idx(input logic [6:0] xx, input logic [6:0] yy);
    logic [31:0] t;
    t = 32'(xx) * 32'(GRID_HEIGHT) + 32'(yy);
    return t[AW-1:0];
  endfunction

  // coordinate modulo grid size, compare and subtract of shifted sizes
  function automatic logic [6:0] wrap_in(input logic [6:0] v, input int n);
    logic [13:0] s;
    s = {7'd0, v};
    for (int k = 6; k >= 0; k--) begin
      if (s >= 14'(n << k)) s = s - 14'(n << k);
    end
    return s[6:0];
  endfunction

  logic [1:0] sdx, sdy;
  always_comb begin
    sdx = 2'd0;
    sdy = 2'd0;
    case (scan_q)
      4'd0: begin sdx = 2'd0; sdy = 2'd0; end
      4'd1: begin sdx = 2'd0; sdy = 2'd1; end
      4'd2: begin sdx = 2'd0; sdy = 2'd2; end
      4'd3: begin sdx = 2'd1; sdy = 2'd0; end
      4'd5: begin sdx = 2'd1; sdy = 2'd2; end
      4'd6: begin sdx = 2'd2; sdy = 2'd0; end
      4'd7: begin sdx = 2'd2; sdy = 2'd1; end
      default: begin sdx = 2'd2; sdy = 2'd2; end
    endcase
  end
  logic [6:0] nx, ny;
  assign nx = wrap_add(x_q, sdx, GRID_WIDTH);
  assign ny = wrap_add(y_q, sdy, GRID_HEIGHT);

  // slot of the mask bit that was read last cycle
  logic [3:0] prev_slot;
  logic [2:0] prev_bit;
  assign prev_slot = (scan_q == 4'd5) ? 4'd3 : scan_q - 4'd1;
  assign prev_bit  = (prev_slot > 4'd4) ? 3'(prev_slot - 4'd1) : prev_slot[2:0];

  // counts including the neighbor arriving from the ram this cycle
  logic       last_fish, last_free;
  logic [3:0] nfish_all, nfree_all;
  assign last_fish = mem_rd_q.fish != 4'd0;
  assign last_free = (mem_rd_q.fish == 4'd0) && (mem_rd_q.shark == 5'd0);
  assign nfish_all = nfish_q + {3'd0, last_fish};
  assign nfree_all = nfree_q + {3'd0, last_free};

  // candidate lookup: k-th set bit of a mask
  logic        use_fish;
  logic [7:0]  cmask;
  logic [3:0]  ccount;
  logic [3:0]  sel_slot;
  always_comb begin
    logic [3:0] cnt;
    use_fish = (here_q.shark != 5'd0) && (nfish_q != 4'd0);
    cmask  = use_fish ? fmask_q : emask_q;
    ccount = use_fish ? nfish_q : nfree_q;
    sel_slot = 4'd0;
    cnt = 4'd0;
    for (int b = 0; b < 8; b++) begin
      if (cmask[b]) begin
        if (cnt == rem_q[3:0]) sel_slot = (b >= 4) ? 4'(b + 1) : 4'(b);
        cnt = cnt + 4'd1;
      end
    end
  end
  logic [1:0] sel_dx, sel_dy;
  always_comb begin
    case (sel_slot)
      4'd0, 4'd1, 4'd2: sel_dx = 2'd0;
      4'd3, 4'd5:       sel_dx = 2'd1;
      default:          sel_dx = 2'd2;
    endcase
    case (sel_slot)
      4'd0, 4'd3, 4'd6: sel_dy = 2'd0;
      4'd1, 4'd7:       sel_dy = 2'd1;
      default:          sel_dy = 2'd2;
    endcase
  end

  // rule evaluation on here cell
  logic [4:0] s_moved, s_behind;
  logic [5:0] s_hung;
  logic [3:0] f_moved, f_behind;
  logic       starve;
  always_comb begin
    if (here_q.shark >= sbreed_q) begin s_behind = 5'd1; s_moved = 5'd1; end
    else begin s_behind = 5'd0; s_moved = here_q.shark + 5'd1; end
    s_hung = {1'b0, here_q.hunger} + 6'd1;
    starve = s_hung >= {1'b0, starve_q};
    if (here_q.fish >= fbreed_q) begin f_behind = 4'd1; f_moved = 4'd1; end
    else begin f_behind = 4'd0; f_moved = here_q.fish + 4'd1; end
  end

  logic acc_in;
  assign req_ready_o = (state_q == ST_IDLE) && !res_valid_q;
  assign acc_in = req_valid_i && req_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (clr_q == CW'(Cells - 1)) state_d = ST_IDLE;
      ST_IDLE:     if (acc_in) state_d = ST_RDHERE;
      ST_RDHERE: begin
        if (cmd_q == CMD_UPDATE) state_d = ST_SCAN;
        else if (cmd_q == CMD_WRITE) state_d = ST_WRHERE;
        else state_d = ST_OUT;
      end
      ST_SCAN:     if (scan_q == 4'd8) state_d = ST_SCANLAST;
      ST_SCANLAST: begin
        // last neighbor is still on the ram output, use the full counts
        if (here_q.shark == 5'd0 && here_q.fish == 4'd0) state_d = ST_RDOUT;
        else if (here_q.shark == 5'd0 && nfree_all == 4'd0) state_d = ST_WRHERE;
        else if (here_q.shark != 5'd0 && nfish_all == 4'd0 && nfree_all == 4'd0)
          state_d = ST_WRHERE;
        else state_d = ST_DIV;
      end
      ST_DIV:      if (dstep_q == 5'd16) state_d = ST_RDDEST;
      ST_RDDEST:   state_d = ST_WRDEST;
      ST_WRDEST:   state_d = ST_WRHERE;
      ST_WRHERE:   state_d = ST_RDOUT;
      ST_RDOUT:    state_d = ST_OUT;
      ST_OUT:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // here cell value written back
  cell_t here_new;
  always_comb begin
    here_new = here_q;
    if (cmd_q == CMD_WRITE) here_new = win_q;
    else if (here_q.shark != 5'd0) begin
      if (nfish_q != 4'd0) begin
        here_new.shark = s_behind; here_new.hunger = 5'd0;
      end else if (nfree_q != 4'd0) begin
        here_new.hunger = 5'd0;
        here_new.shark = starve ? 5'd0 : s_behind;
      end else if (starve) begin
        here_new.shark = 5'd0; here_new.hunger = 5'd0;
      end else begin
        here_new.shark = s_moved; here_new.hunger = s_hung[4:0];
      end
    end else if (here_q.fish != 4'd0) begin
      here_new.fish = (nfree_q != 4'd0) ? f_behind : f_moved;
    end
  end

  cell_t dest_new;
  always_comb begin
    dest_new = mem_rd_q;
    if (here_q.shark != 5'd0) begin
      if (nfish_q != 4'd0) begin
        dest_new.fish = 4'd0; dest_new.shark = s_moved; dest_new.hunger = 5'd0;
      end else if (starve) begin
        dest_new.shark = 5'd0; dest_new.hunger = 5'd0;
      end else begin
        dest_new.shark = s_moved; dest_new.hunger = s_hung[4:0];
      end
    end else begin
      dest_new.fish = f_moved;
    end
  end

  // ram port control
  always_comb begin
    mem_we = 1'b0;
    mem_wd = here_new;
    mem_addr = idx(x_q, y_q);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1; mem_wd = '0; mem_addr = clr_q[AW-1:0];
      end
      ST_SCAN:  mem_addr = idx(nx, ny);
      ST_RDDEST: mem_addr = idx(dx_q, dy_q);
      ST_WRDEST: begin
        mem_we = 1'b1; mem_wd = dest_new; mem_addr = idx(dx_q, dy_q);
      end
      ST_WRHERE: mem_we = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + CW'(1);
      if (state_q == ST_OUT) res_valid_q <= 1'b1;
      else if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      cmd_q  <= command_i;
      x_q    <= wrap_in(cell_x_i, GRID_WIDTH);
      y_q    <= wrap_in(cell_y_i, GRID_HEIGHT);
      win_q  <= '{fish: fish_age_in_i, shark: shark_age_in_i, hunger: hunger_in_i};
      pick_q <= random_pick_i;
    end
    unique case (state_q)
      ST_RDHERE: begin
        dx_q <= x_q; dy_q <= y_q;
        oc_q <= OC_RW;
        scan_q <= 4'd0; nfish_q <= '0; nfree_q <= '0;
        fmask_q <= '0; emask_q <= '0;
      end
      ST_SCAN, ST_SCANLAST: begin
        if (scan_q == 4'd0 && state_q == ST_SCAN) here_q <= mem_rd_q;
        if (scan_q != 4'd0 || state_q == ST_SCANLAST) begin
          if (mem_rd_q.fish != 4'd0) begin
            fmask_q[prev_bit] <= 1'b1; nfish_q <= nfish_q + 4'd1;
          end
          if (mem_rd_q.fish == 4'd0 && mem_rd_q.shark == 5'd0) begin
            emask_q[prev_bit] <= 1'b1; nfree_q <= nfree_q + 4'd1;
          end
        end
        if (state_q == ST_SCAN) scan_q <= (scan_q == 4'd3) ? 4'd5 : scan_q + 4'd1;
        rem_q <= '0; dstep_q <= '0;
      end
      ST_DIV: begin
        // restoring remainder, one bit of the pick a cycle
        if (dstep_q != 5'd16) begin
          logic [16:0] t;
          t = {rem_q, pick_q[4'd15 - dstep_q[3:0]]};
          if (t >= 17'(ccount)) t = t - 17'(ccount);
          rem_q <= t[15:0];
          dstep_q <= dstep_q + 5'd1;
        end else begin
          dx_q <= wrap_add(x_q, sel_dx, GRID_WIDTH);
          dy_q <= wrap_add(y_q, sel_dy, GRID_HEIGHT);
        end
      end
      default: ;
    endcase
    if (state_q == ST_SCANLAST) begin
      here_q <= here_q;
    end
    if (state_q == ST_WRHERE && cmd_q == CMD_UPDATE) begin
      if (here_q.shark != 5'd0) begin
        if (nfish_q != 4'd0) oc_q <= OC_SHARK_ATE;
        else if (starve) oc_q <= OC_STARVED;
        else if (nfree_q != 4'd0) oc_q <= OC_SHARK_MOV;
        else oc_q <= OC_SHARK_STY;
      end else oc_q <= (nfree_q != 4'd0) ? OC_FISH_MOVE : OC_FISH_STAY;
    end
    if (state_q == ST_SCANLAST && here_q.shark == 5'd0 && here_q.fish == 4'd0)
      oc_q <= OC_EMPTY;
    if (state_q == ST_OUT) dcell_q <= mem_rd_q;
  end

  assign res_valid_o = res_valid_q;
  assign fish_age_o  = dcell_q.fish;
  assign shark_age_o = dcell_q.shark;
  assign hunger_o    = dcell_q.hunger;
  assign dest_x_o    = dx_q;
  assign dest_y_o    = dy_q;
  assign outcome_o   = oc_q;

  `ASSERT_IMPL(a_no_req_in_clear, state_q == ST_CLEAR, !req_ready_o)
  `ASSERT_IMPL(a_ready_idle, req_ready_o, state_q == ST_IDLE)
  `ASSERT_IMPL(a_out_then_valid, state_q == ST_OUT, ##1 res_valid_q)
  `ASSERT_IMPL(a_div_count, state_q == ST_DIV, ccount != 4'd0)
endmodule
`default_nettype wire

// ===== test/tb_predator_prey_cell_update.sv =====
// ----------------------------------------------------------------------------
// tb_predator_prey_cell_update
// self-checking bench for the predator-prey cell engine: directed and random
// requests against an in-bench grid predictor, with random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none
module tb_predator_prey_cell_update;
  import ppcu_pkg::*;

  localparam int GW = 128;
  localparam int GH = 128;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [3:0] fish;
    logic [4:0] shark;
    logic [4:0] hunger;
    logic [6:0] dx;
    logic [6:0] dy;
    outcome_e   oc;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [4:0] cfg_data_i = '0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  logic [1:0] command_i = '0;
  logic [6:0] cell_x_i = '0;
  logic [6:0] cell_y_i = '0;
  logic [3:0] fish_age_in_i = '0;
  logic [4:0] shark_age_in_i = '0;
  logic [4:0] hunger_in_i = '0;
  logic [15:0] random_pick_i = '0;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  logic [3:0] fish_age_o;
  logic [4:0] shark_age_o;
  logic [4:0] hunger_o;
  logic [6:0] dest_x_o;
  logic [6:0] dest_y_o;
  logic [2:0] outcome_o;

  predator_prey_cell_update #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) i_dut (.*);

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state: grid copy and breeding/starvation settings
  cell_t grid_model [GW*GH];
  logic [3:0] fish_breed;
  logic [4:0] shark_breed;
  logic [4:0] starve_lim;
  cell_result_t pending_results[$];
  int errors = 0;
  int n_results = 0;
  int oc_seen [8];
  longint cycles = 0;
  bit long_hold = 1'b0;   // receiver hold-off in progress
  int rx_wait_max = 13;

  function automatic int cidx(int x, int y);
    return (x % GW) * GH + (y % GH);
  endfunction

  // apply one request to the grid copy and return what the block must report
  function automatic cell_result_t predict_cell(logic [1:0] cmd, int x, int y,
      logic [3:0] f_in, logic [4:0] s_in, logic [4:0] h_in, int pick);
    cell_result_t r;
    int fx[8], fy[8], ex[8], ey[8];
    int nfish, nfree, nx, ny, k, here, d;
    int behind, moved, hung;
    cell_t c;
    nfish = 0;
    nfree = 0;
    x = x % GW;
    y = y % GH;
    here = cidx(x, y);
    r.dx = 7'(x);
    r.dy = 7'(y);
    r.oc = OC_RW;
    if (cmd == CMD_WRITE) begin
      grid_model[here] = '{fish: f_in, shark: s_in, hunger: h_in};
    end else if (cmd == CMD_UPDATE) begin
      // neighbor scan: column offset outer, row offset inner
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (i == 1 && j == 1) continue;
          nx = (x + i + GW - 1) % GW;
          ny = (y + j + GH - 1) % GH;
          c = grid_model[cidx(nx, ny)];
          if (c.fish != 0) begin
            fx[nfish] = nx; fy[nfish] = ny; nfish++;
          end
          if (c.fish == 0 && c.shark == 0) begin
            ex[nfree] = nx; ey[nfree] = ny; nfree++;
          end
        end
      end
      c = grid_model[here];
      if (c.shark != 0) begin
        if (c.shark >= shark_breed) begin
          behind = 1; moved = 1;
        end else begin
          behind = 0; moved = c.shark + 1;
        end
        hung = c.hunger + 1;
        if (nfish != 0) begin
          // eat a neighboring fish
          k = pick % nfish;
          d = cidx(fx[k], fy[k]);
          grid_model[d].fish = '0;
          grid_model[d].shark = moved[4:0];
          grid_model[d].hunger = '0;
          grid_model[here].shark = behind[4:0];
          grid_model[here].hunger = '0;
          r.dx = 7'(fx[k]); r.dy = 7'(fy[k]); r.oc = OC_SHARK_ATE;
        end else if (nfree != 0) begin
          k = pick % nfree;
          d = cidx(ex[k], ey[k]);
          grid_model[here].hunger = '0;
          r.dx = 7'(ex[k]); r.dy = 7'(ey[k]);
          if (hung >= starve_lim) begin
            // starves on arrival
            grid_model[d].shark = '0;
            grid_model[d].hunger = '0;
            grid_model[here].shark = '0;
            r.oc = OC_STARVED;
          end else begin
            grid_model[d].shark = moved[4:0];
            grid_model[d].hunger = hung[4:0];
            grid_model[here].shark = behind[4:0];
            r.oc = OC_SHARK_MOV;
          end
        end else if (hung >= starve_lim) begin
          grid_model[here].shark = '0;
          grid_model[here].hunger = '0;
          r.oc = OC_STARVED;
        end else begin
          grid_model[here].shark = moved[4:0];
          grid_model[here].hunger = hung[4:0];
          r.oc = OC_SHARK_STY;
        end
      end else if (c.fish != 0) begin
        if (c.fish >= fish_breed) begin
          behind = 1; moved = 1;
        end else begin
          behind = 0; moved = c.fish + 1;
        end
        if (nfree != 0) begin
          k = pick % nfree;
          grid_model[cidx(ex[k], ey[k])].fish = moved[3:0];
          grid_model[here].fish = behind[3:0];
          r.dx = 7'(ex[k]); r.dy = 7'(ey[k]); r.oc = OC_FISH_MOVE;
        end else begin
          grid_model[here].fish = moved[3:0];
          r.oc = OC_FISH_STAY;
        end
      end else begin
        r.oc = OC_EMPTY;
      end
    end
    r.fish = grid_model[here].fish;
    r.shark = grid_model[here].shark;
    r.hunger = grid_model[here].hunger;
    return r;
  endfunction

  // one request: random gap, then hold valid until accepted
  // valid stays up after acceptance only when the next request follows at once
  task automatic send_cell_req(logic [1:0] cmd, int x, int y, logic [3:0] f,
      logic [4:0] s, logic [4:0] h, logic [15:0] pick, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    command_i <= cmd;
    cell_x_i <= x[6:0];
    cell_y_i <= y[6:0];
    fish_age_in_i <= f;
    shark_age_in_i <= s;
    hunger_in_i <= h;
    random_pick_i <= pick;
    do @(posedge clk_i); while (!req_ready_o);
    pending_results.push_back(predict_cell(cmd, x, y, f, s, h, pick));
  endtask

  // settle: wait for the result queue to drain plus some slack
  task automatic drain_results();
    req_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // register write, only while idle
  task automatic write_setting(logic [1:0] idx, logic [4:0] val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FISH_BREED:  fish_breed = val[3:0];
      REG_SHARK_BREED: shark_breed = val;
      REG_STARVE:      starve_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [3:0] fb, logic [4:0] sb, logic [4:0] sl);
    write_setting(REG_FISH_BREED, {1'b0, fb});
    write_setting(REG_SHARK_BREED, sb);
    write_setting(REG_STARVE, sl);
  endtask

  // result checker: compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    cell_result_t e;
    if (rst_ni && res_valid_o && res_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        oc_seen[e.oc]++;
        if (fish_age_o !== e.fish) begin
          $error("fish_age exp %0d got %0d", e.fish, fish_age_o); errors++;
        end
        if (shark_age_o !== e.shark) begin
          $error("shark_age exp %0d got %0d", e.shark, shark_age_o); errors++;
        end
        if (hunger_o !== e.hunger) begin
          $error("hunger exp %0d got %0d", e.hunger, hunger_o); errors++;
        end
        if (dest_x_o !== e.dx) begin
          $error("dest_x exp %0d got %0d", e.dx, dest_x_o); errors++;
        end
        if (dest_y_o !== e.dy) begin
          $error("dest_y exp %0d got %0d", e.dy, dest_y_o); errors++;
        end
        if (outcome_o !== e.oc) begin
          $error("outcome exp %0d got %0d", e.oc, outcome_o); errors++;
        end
      end
    end
  end

  // receiver: random stall per result, or a long hold-off when requested
  initial begin
    int stall;
    forever begin
      if (long_hold) begin
        res_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      stall = $urandom_range(0, rx_wait_max);
      if (stall != 0) begin
        res_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(res_valid_o && res_ready_i));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_predator_prey_cell_update failed");
      $finish;
    end
  end

  // directed: extremes of every field, all commands, wrap at the grid edge
  task automatic test_directed();
    send_cell_req(CMD_READ, 0, 0, 0, 0, 0, 0);              // cleared after reset
    send_cell_req(CMD_UPDATE, 5, 5, 0, 0, 0, 16'hffff);     // empty cell
    send_cell_req(CMD_WRITE, 127, 127, 15, 31, 31, 16'hffff);
    send_cell_req(CMD_READ3, 127, 127, 0, 0, 0, 0);        // command 3 reads
    send_cell_req(CMD_UPDATE, 127, 127, 0, 0, 0, 16'hffff); // shark at corner
    send_cell_req(CMD_WRITE, 0, 0, 3, 0, 0, 0);            // fish, wrap neighbors
    send_cell_req(CMD_UPDATE, 0, 0, 0, 0, 0, 16'h1234);
    send_cell_req(CMD_WRITE, 10, 10, 0, 9, 2, 0);          // shark next to fish
    send_cell_req(CMD_WRITE, 11, 11, 4, 0, 0, 0);
    send_cell_req(CMD_WRITE, 9, 9, 1, 0, 0, 0);
    send_cell_req(CMD_UPDATE, 10, 10, 0, 0, 0, 16'd1);
    send_cell_req(CMD_WRITE, 20, 20, 5, 3, 1, 0);          // shark and fish share
    send_cell_req(CMD_UPDATE, 20, 20, 0, 0, 0, 16'd7);
    send_cell_req(CMD_READ, 20, 20, 0, 0, 0, 0);
    // boxed-in fish stays, then a shark next to it eats it
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        send_cell_req(CMD_WRITE, 40 + i, 40 + j, 0, 1, 0, 0);
    send_cell_req(CMD_WRITE, 41, 41, 15, 0, 0, 0);
    send_cell_req(CMD_UPDATE, 41, 41, 0, 0, 0, 0);
    send_cell_req(CMD_UPDATE, 40, 40, 0, 0, 0, 0);
  endtask

  // random clusters in a small window so that animals meet and interact
  task automatic test_random(int n);
    int bx, by, sel;
    logic [1:0] cmd;
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) begin
        bx = $urandom_range(0, 127);
        by = $urandom_range(0, 127);
      end
      sel = $urandom_range(0, 9);
      cmd = sel < 4 ? CMD_WRITE : (sel < 8 ? CMD_UPDATE : (sel == 8 ? CMD_READ : CMD_READ3));
      send_cell_req(cmd, (bx + $urandom_range(0, 4)) % 128, (by + $urandom_range(0, 4)) % 128,
                    $urandom_range(0, 1) ? 4'($urandom_range(1, 15)) : 4'd0,
                    $urandom_range(0, 2) == 0 ? 5'($urandom_range(1, 31)) : 5'd0,
                    5'($urandom_range(0, 31)), 16'($urandom));
    end
  endtask

  // receiver holds off while requests keep coming, then a sender pause
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int k = 0; k < 12; k++)
      send_cell_req(CMD_READ, k, 3, 0, 0, 0, 16'($urandom), 1'b1);
    drain_results();
    test_random(20);
  endtask

  initial begin
    fish_breed = 4;
    shark_breed = 10;
    starve_lim = 8;
    foreach (grid_model[i]) grid_model[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(200);
    set_all(4'd1, 5'd1, 5'd1);      // lowest nonzero settings
    test_random(120);
    set_all(4'd15, 5'd31, 5'd31);   // highest settings
    test_random(120);
    set_all(4'd0, 5'd0, 5'd0);      // zero: everything breeds, starves
    test_random(60);
    set_all(4'd2, 5'd5, 5'd3);
    rx_wait_max = 0;                // stretch with no receiver stalls
    test_random(100);
    rx_wait_max = 13;
    test_backpressure();
    test_random(100);
    drain_results();
    $display("covered %0d results; outcomes rw %0d fmove %0d fstay %0d ate %0d",
             n_results, oc_seen[0], oc_seen[1], oc_seen[2], oc_seen[3]);
    $display("smove %0d sstay %0d starved %0d empty %0d",
             oc_seen[4], oc_seen[5], oc_seen[6], oc_seen[7]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_predator_prey_cell_update passed");
    end else begin
      $display("tb_predator_prey_cell_update failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
